// ===== sv/lfu_pkg.sv =====
// shared constants, types and state codes for the lfu cache table
package lfu_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 32;
   localparam int STAMP_W     = 64;
   localparam int CAP_W       = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [STAMP_W-1:0] stamp_type;
   typedef logic [CAP_W-1:0]   cap_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;

   typedef enum logic {
      KIND_GET = 1'b0,
      KIND_PUT = 1'b1
   } kind_type;

   typedef struct packed {
      key_type   key;
      value_type value;
      count_type use_count;
      stamp_type last_use;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

endpackage

// ===== sv/lfu_if.sv =====
// handshake channels of the lfu cache table: request, response, capacity register write
interface lfu_req_if;
   logic               valid;
   logic               ready;
   lfu_pkg::kind_type  kind;
   lfu_pkg::key_type   key;
   lfu_pkg::value_type value;

   modport source (output valid, output kind, output key, output value, input ready);
   modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   lfu_pkg::value_type read_value;
   logic               evicted;
   lfu_pkg::key_type   evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

interface lfu_csr_if;
   logic             valid;
   logic             ready;
   lfu_pkg::cap_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/lfu_cache_table.sv =====
// lfu cache table: one entry scanned per cycle through a shared victim/match comparator
// sequence: a ram lead-in step, a scan step per entry, then a decide step that writes back
//   and loads the output register
// a new request is taken only in idle, once the decide step of the last is done; a response
//   held by the sink stretches the decide step
// reset: valid bits cleared, stamp counter zero, capacity 16; no clearing pass
module lfu_cache_table (
   input logic         clock,
   input logic         reset,
   lfu_req_if.sink     req_ch,
   lfu_rsp_if.source   rsp_ch,
   lfu_csr_if.sink     csr_ch
);
   import lfu_pkg::*;

   state_type state_ff, state_in;
   cnt_type   cnt_ff, cnt_in;
   kind_type  kind_ff, kind_in;
   key_type   key_ff, key_in;
   value_type value_ff, value_in;

   logic      found_ff, found_in;
   idx_type   slot_ff, slot_in;
   entry_type hit_rec_ff, hit_rec_in;
   logic      have_free_ff, have_free_in;
   idx_type   free_slot_ff, free_slot_in;
   cnt_type   used_ff, used_in;
   logic      have_victim_ff, have_victim_in;
   idx_type   victim_ff, victim_in;
   entry_type victim_rec_ff, victim_rec_in;

   stamp_type                  seq_ff, seq_in;
   cap_type                    capacity_ff, capacity_in;
   logic [MAX_ENTRIES-1:0]     entry_valid_ff, entry_valid_in;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_hit_ff, rsp_hit_in;
   value_type rsp_read_value_ff, rsp_read_value_in;
   logic      rsp_evicted_ff, rsp_evicted_in;
   key_type   rsp_evicted_key_ff, rsp_evicted_key_in;

   logic      wr_en;
   idx_type   wr_addr;
   entry_type wr_data;
   idx_type   rd_addr;
   entry_type rd_data;

   idx_type   eval_idx;
   logic      eval_en;
   logic      better;
   cnt_type   cap_eff;
   stamp_type seq_next;
   logic      do_insert;
   idx_type   ins_slot;

   lfu_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.read_value  = rsp_read_value_ff;
   assign rsp_ch.evicted     = rsp_evicted_ff;
   assign rsp_ch.evicted_key = rsp_evicted_key_ff;

   assign rd_addr  = idx_type'(cnt_ff);
   assign eval_idx = idx_type'(cnt_ff - cnt_type'(1));
   assign eval_en  = (state_ff == ST_SCAN) && (cnt_ff != '0) && entry_valid_ff[eval_idx];
   assign seq_next = seq_ff + stamp_type'(1);
   assign cap_eff  = (32'(capacity_ff) > 32'(MAX_ENTRIES)) ? cnt_type'(MAX_ENTRIES)
                                                           : cnt_type'(capacity_ff);

   // shared comparator: lower count wins, then older last use; ties keep lower slot
   assign better = !have_victim_ff
                   || (rd_data.use_count < victim_rec_ff.use_count)
                   || ((rd_data.use_count == victim_rec_ff.use_count)
                       && (rd_data.last_use < victim_rec_ff.last_use));

   always_comb begin
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      kind_in            = kind_ff;
      key_in             = key_ff;
      value_in           = value_ff;
      found_in           = found_ff;
      slot_in            = slot_ff;
      hit_rec_in         = hit_rec_ff;
      have_free_in       = have_free_ff;
      free_slot_in       = free_slot_ff;
      used_in            = used_ff;
      have_victim_in     = have_victim_ff;
      victim_in          = victim_ff;
      victim_rec_in      = victim_rec_ff;
      seq_in             = seq_ff;
      capacity_in        = capacity_ff;
      entry_valid_in     = entry_valid_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in         = rsp_hit_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_evicted_key_in = rsp_evicted_key_ff;
      wr_en              = 1'b0;
      wr_addr            = slot_ff;
      wr_data            = hit_rec_ff;
      do_insert          = 1'b0;
      ins_slot           = free_slot_ff;

      if (csr_ch.valid) begin
         capacity_in = csr_ch.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               kind_in        = req_ch.kind;
               key_in         = req_ch.key;
               value_in       = req_ch.value;
               cnt_in         = '0;
               found_in       = 1'b0;
               have_free_in   = 1'b0;
               have_victim_in = 1'b0;
               used_in        = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // ram read runs one entry ahead of the compare
            if (cnt_ff != '0) begin
               if (eval_en) begin
                  used_in = used_ff + cnt_type'(1);
                  if (!found_ff && (rd_data.key == key_ff)) begin
                     found_in   = 1'b1;
                     slot_in    = eval_idx;
                     hit_rec_in = rd_data;
                  end
                  if (better) begin
                     have_victim_in = 1'b1;
                     victim_in      = eval_idx;
                     victim_rec_in  = rd_data;
                  end
               end else if (!have_free_ff) begin
                  have_free_in = 1'b1;
                  free_slot_in = eval_idx;
               end
            end
            cnt_in = cnt_ff + cnt_type'(1);
            if (cnt_ff == cnt_type'(MAX_ENTRIES)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!(rsp_valid_ff && !rsp_ch.ready)) begin
               rsp_valid_in       = 1'b1;
               rsp_hit_in         = 1'b0;
               rsp_read_value_in  = '0;
               rsp_evicted_in     = 1'b0;
               rsp_evicted_key_in = '0;
               state_in           = ST_IDLE;
               if (found_ff) begin
                  rsp_hit_in        = 1'b1;
                  wr_en             = 1'b1;
                  wr_addr           = slot_ff;
                  wr_data           = hit_rec_ff;
                  wr_data.last_use  = seq_next;
                  if (hit_rec_ff.use_count != '1) begin
                     wr_data.use_count = hit_rec_ff.use_count + count_type'(1);
                  end
                  if (kind_ff == KIND_PUT) begin
                     wr_data.value = value_ff;
                  end else begin
                     rsp_read_value_in = hit_rec_ff.value;
                  end
                  seq_in = seq_next;
               end else if ((kind_ff == KIND_PUT) && (cap_eff != '0)) begin
                  if ((used_ff >= cap_eff) || !have_free_ff) begin
                     if (have_victim_ff) begin
                        do_insert          = 1'b1;
                        ins_slot           = victim_ff;
                        rsp_evicted_in     = 1'b1;
                        rsp_evicted_key_in = victim_rec_ff.key;
                     end
                  end else begin
                     do_insert = 1'b1;
                     ins_slot  = free_slot_ff;
                  end
                  if (do_insert) begin
                     wr_en                    = 1'b1;
                     wr_addr                  = ins_slot;
                     wr_data.key              = key_ff;
                     wr_data.value            = value_ff;
                     wr_data.use_count        = count_type'(1);
                     wr_data.last_use         = seq_next;
                     entry_valid_in[ins_slot] = 1'b1;
                     seq_in                   = seq_next;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         seq_ff         <= '0;
         capacity_ff    <= CAP_RESET;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seq_ff         <= seq_in;
         capacity_ff    <= capacity_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff             <= cnt_in;
      kind_ff            <= kind_in;
      key_ff             <= key_in;
      value_ff           <= value_in;
      found_ff           <= found_in;
      slot_ff            <= slot_in;
      hit_rec_ff         <= hit_rec_in;
      have_free_ff       <= have_free_in;
      free_slot_ff       <= free_slot_in;
      used_ff            <= used_in;
      have_victim_ff     <= have_victim_in;
      victim_ff          <= victim_in;
      victim_rec_ff      <= victim_rec_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_evicted_ff     <= rsp_evicted_in;
      rsp_evicted_key_ff <= rsp_evicted_key_in;
   end

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_SCAN))
      else $error("request beat did not start a scan");

   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DECIDE))
      else $error("response raised outside the decide step");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_ff))
      else $error("hit and eviction reported on one beat");

   a_evict_keeps_occupancy: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DECIDE) && rsp_evicted_in && !(rsp_valid_ff && !rsp_ch.ready))
      |=> ($countones(entry_valid_ff) == $past($countones(entry_valid_ff))))
      else $error("eviction changed the number of valid entries");

   a_no_write_while_scanning: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DECIDE) |-> !wr_en)
      else $error("entry ram written outside the decide step");
endmodule

// ===== sv/lfu_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== dv/tb_top.sv =====
// testbench for the lfu cache table: directed and random get/put traffic against a predictor
`timescale 1ns / 100ps

module tb_top;
   import lfu_pkg::*;

   localparam int CYCLE_LIMIT = 300_000;
   localparam int POOL_SIZE   = 24;
   localparam int PHASE_ITEMS = 100;
   localparam int SETTLE_GAP  = 25;

   typedef struct packed {
      logic      hit;
      value_type read_value;
      logic      evicted;
      key_type   evicted_key;
   } outcome_type;

   logic clock;
   logic reset;

   lfu_req_if req_ch ();
   lfu_rsp_if rsp_ch ();
   lfu_csr_if csr_ch ();

   lfu_cache_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // predictor copy of the cache
   logic      slot_valid [MAX_ENTRIES];
   key_type   slot_key   [MAX_ENTRIES];
   value_type slot_value [MAX_ENTRIES];
   count_type slot_count [MAX_ENTRIES];
   stamp_type slot_stamp [MAX_ENTRIES];
   stamp_type stamp_counter;
   cap_type   cap_setting;

   outcome_type pending_outcomes [$];
   key_type     key_pool [POOL_SIZE];

   int fail_count = 0;
   int request_total;
   int hit_total = 0;
   int evict_total = 0;
   int cap_write_total;
   int cycle_count;
   int req_beats;
   int rsp_beats = 0;
   int rsp_wait;
   bit req_quiet;
   bit rsp_quiet = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic outcome_type predict_access(input kind_type kind, input key_type key,
                                                  input value_type value);
      outcome_type res;
      int unsigned eff_cap;
      int unsigned used;
      int match_slot;
      int free_slot;
      int victim_slot;
      int slot;
      res = '0;
      eff_cap = (cap_setting > MAX_ENTRIES) ? MAX_ENTRIES : cap_setting;
      used = 0;
      match_slot = -1;
      free_slot = -1;
      victim_slot = -1;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (slot_valid[i]) begin
            used++;
            if (match_slot < 0 && slot_key[i] == key)
               match_slot = i;
            if (victim_slot < 0 || slot_count[i] < slot_count[victim_slot] ||
                (slot_count[i] == slot_count[victim_slot] &&
                 slot_stamp[i] < slot_stamp[victim_slot]))
               victim_slot = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end

      if (match_slot >= 0) begin
         res.hit = 1'b1;
         if (kind == KIND_PUT)
            slot_value[match_slot] = value;
         else
            res.read_value = slot_value[match_slot];
         if (slot_count[match_slot] != '1)
            slot_count[match_slot] = slot_count[match_slot] + 1'b1;
         stamp_counter = stamp_counter + 1'b1;
         slot_stamp[match_slot] = stamp_counter;
         return res;
      end

      if (kind == KIND_GET || eff_cap == 0)
         return res;

      // full, or capacity dropped under occupancy: replace the victim
      if (used >= eff_cap || free_slot < 0) begin
         if (victim_slot < 0)
            return res;
         res.evicted = 1'b1;
         res.evicted_key = slot_key[victim_slot];
         slot = victim_slot;
      end else begin
         slot = free_slot;
      end

      slot_valid[slot] = 1'b1;
      slot_key[slot] = key;
      slot_value[slot] = value;
      slot_count[slot] = 1;
      stamp_counter = stamp_counter + 1'b1;
      slot_stamp[slot] = stamp_counter;
      return res;
   endfunction

   task automatic send_request(input kind_type kind, input key_type key, input value_type value);
      int gap;
      if (req_beats % 40 == 0)
         req_quiet = ($urandom_range(0, 2) == 0);
      gap = req_quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.key   <= key;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      req_beats++;
      request_total++;
      pending_outcomes.push_back(predict_access(kind, key, value));
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   task automatic write_capacity(input cap_type cap);
      drain_results();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= cap;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      cap_setting = cap;
      cap_write_total++;
   endtask

   // response side: random back-pressure and field compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_response();
            rsp_beats++;
            if (rsp_beats % 40 == 0)
               rsp_quiet = ($urandom_range(0, 2) == 0);
            rsp_wait = rsp_quiet ? 0 : $urandom_range(0, 13);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic check_response();
      outcome_type want;
      if (pending_outcomes.size() == 0) begin
         $error("response beat with no request outstanding");
         fail_count++;
         return;
      end
      want = pending_outcomes.pop_front();
      if (want.hit) hit_total++;
      if (want.evicted) evict_total++;
      if (rsp_ch.hit !== want.hit) begin
         $error("hit: expected %0h, got %0h", want.hit, rsp_ch.hit);
         fail_count++;
      end
      if (rsp_ch.read_value !== want.read_value) begin
         $error("read_value: expected %08h, got %08h", want.read_value, rsp_ch.read_value);
         fail_count++;
      end
      if (rsp_ch.evicted !== want.evicted) begin
         $error("evicted: expected %0h, got %0h", want.evicted, rsp_ch.evicted);
         fail_count++;
      end
      if (rsp_ch.evicted_key !== want.evicted_key) begin
         $error("evicted_key: expected %08h, got %08h", want.evicted_key, rsp_ch.evicted_key);
         fail_count++;
      end
   endtask

   task automatic test_get_put_basics();
      send_request(KIND_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(KIND_GET, 32'hFFFF_FFFF, 32'hAAAA_5555);
      send_request(KIND_PUT, 32'h0000_0000, 32'h1234_5678);
      send_request(KIND_GET, 32'h0000_0000, 32'h0000_0000);
   endtask

   task automatic test_small_capacity_eviction();
      write_capacity(cap_type'(2));
      send_request(KIND_PUT, 32'h0000_0005, 32'h5555_AAAA);
      send_request(KIND_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(KIND_GET, 32'h0000_0005, 32'h0000_0000);
      send_request(KIND_PUT, 32'h0000_0006, 32'h8000_0001);
   endtask

   task automatic test_zero_capacity();
      write_capacity(cap_type'(0));
      send_request(KIND_PUT, 32'h0000_0007, 32'hDEAD_0007);
      send_request(KIND_GET, 32'h0000_0007, 32'h0000_0000);
      send_request(KIND_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(KIND_PUT, 32'h0000_0000, 32'h0F0F_0F0F);
   endtask

   task automatic test_shrink_below_occupancy();
      // oversized setting acts as the built size
      write_capacity(cap_type'(31));
      send_request(KIND_PUT, 32'h8000_0008, 32'h0000_0008);
      send_request(KIND_PUT, 32'h7FFF_FFF9, 32'h0000_0009);
      write_capacity(cap_type'(1));
      send_request(KIND_PUT, 32'h0000_000A, 32'h0000_000A);
      send_request(KIND_PUT, 32'h0000_000B, 32'h0000_000B);
      send_request(KIND_GET, 32'h0000_000A, 32'h0000_0000);
   endtask

   task automatic test_random_traffic();
      cap_type  phase_caps [9];
      kind_type kind;
      key_type  key;
      int       pick;
      phase_caps = '{cap_type'(16), cap_type'(3), cap_type'(31), cap_type'(0), cap_type'(1),
                     cap_type'(8), cap_type'(17), cap_type'(2), cap_type'($urandom_range(0, 31))};
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      foreach (phase_caps[p]) begin
         write_capacity(phase_caps[p]);
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            // skewed pool index gives a spread of use counts
            if (pick < 85)
               key = key_pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))];
            else
               key = $urandom;
            kind = ($urandom_range(0, 9) < 5) ? KIND_PUT : KIND_GET;
            send_request(kind, key, $urandom);
         end
      end
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** lfu_cache_table: FAILED **");
      $finish;
   end

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.kind  <= KIND_GET;
      req_ch.key   <= '0;
      req_ch.value <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.data  <= '0;
      reset        <= 1'b1;
      foreach (slot_valid[i]) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_count[i] = '0;
         slot_stamp[i] = '0;
      end
      stamp_counter = '0;
      cap_setting = CAP_RESET;
      request_total = 0;
      cap_write_total = 0;
      req_beats = 0;
      req_quiet = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_get_put_basics();
      test_small_capacity_eviction();
      test_zero_capacity();
      test_shrink_below_occupancy();
      test_random_traffic();
      drain_results();

      $display("ran %0d get/put requests: %0d hits, %0d evictions", request_total, hit_total,
               evict_total);
      $display("capacity rewritten %0d times, including zero, one and oversized settings",
               cap_write_total);
      if (fail_count == 0)
         $display("** lfu_cache_table: PASSED **");
      else
         $display("** lfu_cache_table: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/lfu_pkg.sv
sv/lfu_if.sv
sv/lfu_ram.sv
sv/lfu_cache_table.sv
dv/tb_top.sv
